// ----- hdl/droop_integrator_controller_macros.svh -----
// ----------------------------------------------------------------------------
// Droop integrator controller assertion macros
// Concurrent property shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef DROOP_INTEGRATOR_CONTROLLER_MACROS_SVH
`define DROOP_INTEGRATOR_CONTROLLER_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define DIC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// next-cycle implication, checked on every rising edge outside reset
`define DIC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ----- hdl/dic_pkg.sv -----
// ----------------------------------------------------------------------------
// Droop integrator controller package
// Widths, constants and word types shared by the controller modules.
// ----------------------------------------------------------------------------
package dic_pkg;

  localparam int unsigned REF_W   = 12;
  localparam int unsigned LIM_W   = 11;
  localparam int unsigned ACC_W   = 26;
  localparam int unsigned ACC_FRAC = 14;
  localparam int unsigned GATE_W  = 10;
  localparam int unsigned IMEAS_W = 12;
  localparam int unsigned FREQ_W  = 13;
  localparam int unsigned SLOPE_W = 11;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [ACC_W-1:0] FAST_DECAY  = 26'h0008659;
  localparam logic [ACC_W-1:0] SLOW_DECAY  = 26'h00004FA;
  localparam logic [ACC_W-1:0] INTEG_SMALL = 26'h0004C75;
  localparam logic [ACC_W-1:0] INTEG_LARGE = 26'h0009547;
  localparam logic [ACC_W-1:0] ACC_MAX     = 26'h1668000;

  localparam logic [GATE_W-1:0] GATE_LIMIT = 10'h226;

  localparam logic [REF_W-1:0] DECAY_FAR = 12'hB11;
  localparam logic [REF_W-1:0] INTEG_FAR = 12'hB99;
  localparam logic [REF_W-1:0] REF_RESET = 12'd3149;

  localparam logic [LIM_W-1:0] LOW_LIMIT_RESET   = 11'd192;
  localparam logic [LIM_W-1:0] REARM_LIMIT_RESET = 11'd210;

  localparam logic signed [SLOPE_W-1:0] FREQ_SLOPE = -11'sd678;
  localparam logic [FREQ_W-1:0] FREQ_OFFSET = 13'h1418;
  localparam logic [FREQ_W-1:0] FREQ_HIGH   = 13'h13EC;
  localparam logic [FREQ_W-1:0] FREQ_LOW    = 13'h125C;

  typedef enum logic [1:0] {
    CFG_VOUT_REF    = 2'd0,
    CFG_LOW_LIMIT   = 2'd1,
    CFG_REARM_LIMIT = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [REF_W-1:0] vout_reference;
    logic [LIM_W-1:0] low_current_limit;
    logic [LIM_W-1:0] rearm_current_limit;
  } dic_cfg_t;

  typedef struct packed {
    logic               current_limit;
    logic               system_fault;
    logic               ramp_gate;
    logic               restart_active;
    logic               hold_droop;
    logic               control_reset;
    logic [IMEAS_W-1:0] measured_current;
  } dic_item_t;

  typedef struct packed {
    logic [ACC_W-1:0]  droop_accumulator;
    logic [REF_W-1:0]  target_code;
    logic [GATE_W-1:0] gate_counter;
    logic              limit_clear_seen;
    logic              low_current_latch;
    logic              pin_level;
  } dic_state_t;

  typedef struct packed {
    logic [REF_W-1:0]  vout_target;
    logic [FREQ_W-1:0] init_frequency;
    logic              frequency_load;
    logic              droop_pin;
    logic              enter_mode_four;
    logic              approaching;
    logic              integrating;
    logic              target_reached;
    logic              flags_cleared;
  } dic_result_t;

endpackage

// ----- hdl/dic_freq.sv -----
// ----------------------------------------------------------------------------
// Droop start frequency
// Scales the measured current into a start frequency, clamped to its band.
// ----------------------------------------------------------------------------
module dic_freq import dic_pkg::*; (
  input  logic [IMEAS_W-1:0] measured_current,
  output logic [FREQ_W-1:0]  init_frequency
);

  localparam int unsigned PROD_W = IMEAS_W + SLOPE_W;
  localparam int unsigned SCL_W  = PROD_W - 8;
  localparam int unsigned SUM_W  = SCL_W + 1;

  logic signed [PROD_W-1:0] product;
  logic signed [SCL_W-1:0]  scaled;
  logic signed [SUM_W-1:0]  raw_freq;
  logic signed [SUM_W-1:0]  high_lim;
  logic signed [SUM_W-1:0]  low_lim;

  always_comb begin
    product  = $signed(measured_current) * FREQ_SLOPE;
    scaled   = product[PROD_W-1:8];
    raw_freq = $signed({scaled[SCL_W-1], scaled})
             + $signed({{(SUM_W-FREQ_W){1'b0}}, FREQ_OFFSET});
    high_lim = $signed({{(SUM_W-FREQ_W){1'b0}}, FREQ_HIGH});
    low_lim  = $signed({{(SUM_W-FREQ_W){1'b0}}, FREQ_LOW});
    priority if (raw_freq > high_lim) begin
      init_frequency = FREQ_HIGH;
    end else if (raw_freq < low_lim) begin
      init_frequency = FREQ_LOW;
    end else begin
      init_frequency = raw_freq[FREQ_W-1:0];
    end
  end

endmodule

// ----- hdl/dic_core.sv -----
// ----------------------------------------------------------------------------
// Droop integrator tick logic
// Computes the next controller state and the result word of one tick.
// ----------------------------------------------------------------------------
module dic_core import dic_pkg::*; (
  input  dic_cfg_t    cfg,
  input  dic_item_t   item,
  input  dic_state_t  state,
  output dic_state_t  state_next,
  output dic_result_t result
);

  localparam int unsigned SHIFT_W = ACC_W - ACC_FRAC;

  function automatic logic [REF_W-1:0] target_of(input logic [REF_W-1:0] ref_code,
                                                 input logic [ACC_W-1:0] acc);
    logic [REF_W:0] diff;
    diff = {1'b0, ref_code} - {{(REF_W+1-SHIFT_W){1'b0}}, acc[ACC_W-1:ACC_FRAC]};
    return diff[REF_W] ? '0 : diff[REF_W-1:0];
  endfunction

  logic signed [IMEAS_W:0] imeas;
  logic                    low_hit;
  logic                    rearm_ok;
  logic                    seen_mid;
  logic                    latch_mid;
  logic                    decay_cond;
  logic                    integ_force;
  logic                    do_decay;
  logic                    do_integ;
  logic [ACC_W-1:0]        delta;
  logic [GATE_W-1:0]       gate_inc;
  logic [GATE_W-1:0]       gate_next;
  logic signed [ACC_W:0]   acc_dec;
  logic                    dec_done;
  logic [ACC_W-1:0]        acc_int;
  logic                    int_sat;
  logic [ACC_W-1:0]        acc_int_sat;
  logic [FREQ_W-1:0]       freq;

  dic_freq u_freq (
    .measured_current (item.measured_current),
    .init_frequency   (freq)
  );

  always_comb begin
    imeas    = $signed({item.measured_current[IMEAS_W-1], item.measured_current});
    low_hit  = imeas <= $signed({2'b00, cfg.low_current_limit});
    rearm_ok = imeas <= $signed({2'b00, cfg.rearm_current_limit});

    seen_mid  = state.limit_clear_seen;
    latch_mid = state.low_current_latch;
    if (!item.current_limit) begin
      latch_mid = 1'b0;
      seen_mid  = 1'b1;
    end
    if (seen_mid && item.current_limit) begin
      if (low_hit) begin
        latch_mid = 1'b1;
      end
      seen_mid = 1'b0;
    end

    decay_cond  = (!item.current_limit || item.ramp_gate)
                && (state.target_code != cfg.vout_reference) && !item.system_fault;
    integ_force = latch_mid || item.system_fault;
    do_decay    = !item.control_reset && !item.hold_droop && decay_cond;
    do_integ    = !item.control_reset && !item.hold_droop && !decay_cond
                && (integ_force || (state.pin_level && rearm_ok));

    delta     = FAST_DECAY;
    gate_inc  = state.gate_counter + 1'b1;
    gate_next = state.gate_counter;
    if (state.target_code > DECAY_FAR) begin
      gate_next = '0;
    end else if (item.current_limit || item.restart_active) begin
      delta = SLOW_DECAY;
      if (item.ramp_gate) begin
        if (gate_inc > GATE_LIMIT) begin
          gate_next = GATE_LIMIT;
        end else begin
          gate_next = gate_inc;
          delta     = '0;
        end
      end
    end
    acc_dec  = $signed({1'b0, state.droop_accumulator}) - $signed({1'b0, delta});
    dec_done = acc_dec[ACC_W] || (acc_dec[ACC_W-1:ACC_FRAC] == '0);

    acc_int = state.droop_accumulator
            + ((state.target_code > INTEG_FAR) ? INTEG_SMALL : INTEG_LARGE);
    int_sat     = acc_int >= ACC_MAX;
    acc_int_sat = int_sat ? ACC_MAX : acc_int;

    state_next = state;
    state_next.limit_clear_seen  = seen_mid;
    state_next.low_current_latch = latch_mid;
    result = '0;
    result.flags_cleared = item.control_reset;

    if (do_decay) begin
      state_next.low_current_latch = 1'b0;
      state_next.gate_counter      = gate_next;
      if (dec_done) begin
        state_next.droop_accumulator = '0;
        state_next.target_code       = cfg.vout_reference;
        state_next.pin_level         = 1'b0;
        result.target_reached        = 1'b1;
      end else begin
        state_next.droop_accumulator = acc_dec[ACC_W-1:0];
        state_next.target_code       = target_of(cfg.vout_reference, acc_dec[ACC_W-1:0]);
        result.approaching           = 1'b1;
      end
    end else if (do_integ) begin
      state_next.droop_accumulator = acc_int_sat;
      state_next.target_code       = target_of(cfg.vout_reference, acc_int_sat);
      if (integ_force) begin
        state_next.pin_level = 1'b1;
      end
      if (int_sat) begin
        result.enter_mode_four = 1'b1;
        if (low_hit) begin
          result.frequency_load = 1'b1;
          result.init_frequency = freq;
        end
      end else begin
        result.integrating = 1'b1;
      end
    end

    result.vout_target = state_next.target_code;
    result.droop_pin   = state_next.pin_level;
  end

endmodule

// ----- hdl/droop_integrator_controller.sv -----
// ----------------------------------------------------------------------------
// Droop integrator controller
// One tick word in, one result word out; keeps the droop integrator state.
// ----------------------------------------------------------------------------
//  channel   direction  word layout (lowest bit first)
//  s_*       in         flags[5:0], measured_current[17:6]
//  m_*       out        vout_target, init_frequency, status flags; tuser=load
//  cfg_*     in         register index, write data
//
//  One word per cycle sustained while the result is not stalled; a result word
//  passes through the input register, then the result register, to the output.
//  The state update for a word happens when it moves from the input register
//  to the result register, so consecutive words see each other's state.
//  Synchronous reset restores the register defaults and empties both stages.
//  A stalled result holds; the input register still takes a word if it is empty.
// ----------------------------------------------------------------------------
module droop_integrator_controller import dic_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [REF_W-1:0]      cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // current_limit, system_fault, ramp_gate, restart_active, hold_droop,
  // control_reset, measured_current[11:0], zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // vout_target[11:0], init_frequency[12:0], droop_pin, enter_mode_four,
  // approaching, integrating, target_reached, flags_cleared, zero fill
  output logic [OUT_DATA_W-1:0] m_tdata,
  // frequency_load
  output logic [0:0]            m_tuser
);

  dic_cfg_t    cfg;
  dic_item_t   in_item;
  logic        in_valid;
  dic_state_t  state;
  dic_state_t  state_next;
  dic_result_t result;
  dic_result_t out_res;
  logic        advance;
  logic        fire;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign fire     = in_valid && advance;

  dic_core u_core (
    .cfg        (cfg),
    .item       (in_item),
    .state      (state),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vout_reference      <= REF_RESET;
      cfg.low_current_limit   <= LOW_LIMIT_RESET;
      cfg.rearm_current_limit <= REARM_LIMIT_RESET;
      in_valid                <= 1'b0;
      m_tvalid                <= 1'b0;
      state.droop_accumulator <= '0;
      state.target_code       <= REF_RESET;
      state.gate_counter      <= '0;
      state.limit_clear_seen  <= 1'b0;
      state.low_current_latch <= 1'b0;
      state.pin_level         <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_VOUT_REF:    cfg.vout_reference      <= cfg_data;
          CFG_LOW_LIMIT:   cfg.low_current_limit   <= cfg_data[LIM_W-1:0];
          CFG_REARM_LIMIT: cfg.rearm_current_limit <= cfg_data[LIM_W-1:0];
          default: ;
        endcase
      end
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        m_tvalid <= in_valid;
      end
      if (fire) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.current_limit    <= s_tdata[0];
      in_item.system_fault     <= s_tdata[1];
      in_item.ramp_gate        <= s_tdata[2];
      in_item.restart_active   <= s_tdata[3];
      in_item.hold_droop       <= s_tdata[4];
      in_item.control_reset    <= s_tdata[5];
      in_item.measured_current <= s_tdata[6 +: IMEAS_W];
    end
    if (fire) begin
      out_res <= result;
    end
  end

  assign m_tdata = {1'b0, out_res.flags_cleared, out_res.target_reached,
                    out_res.integrating, out_res.approaching, out_res.enter_mode_four,
                    out_res.droop_pin, out_res.init_frequency, out_res.vout_target};
  assign m_tuser = out_res.frequency_load;

endmodule

// ----- hdl/dic_checker.sv -----
// ----------------------------------------------------------------------------
// Droop integrator controller checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "droop_integrator_controller_macros.svh"

module dic_checker import dic_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [0:0]            m_tuser
);

  logic [FREQ_W-1:0] freq;
  logic              pin;
  logic              mode_four;
  logic              integ;
  logic              reached;
  logic [4:0]        actions;

  assign freq      = m_tdata[REF_W +: FREQ_W];
  assign pin       = m_tdata[REF_W+FREQ_W];
  assign mode_four = m_tdata[REF_W+FREQ_W+1];
  assign integ     = m_tdata[REF_W+FREQ_W+3];
  assign reached   = m_tdata[REF_W+FREQ_W+4];
  assign actions   = m_tdata[REF_W+FREQ_W+5:REF_W+FREQ_W+1];

  `DIC_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `DIC_ASSERT_SAME(a_load_band, m_tvalid && m_tuser[0], mode_four && freq >= FREQ_LOW && freq <= FREQ_HIGH)
  `DIC_ASSERT_SAME(a_no_load_zero, m_tvalid && !m_tuser[0], freq == '0)
  `DIC_ASSERT_SAME(a_one_action, m_tvalid, $countones(actions) <= 1)
  `DIC_ASSERT_SAME(a_pin_follow, m_tvalid && (integ || mode_four || reached), pin == !reached)

endmodule

bind droop_integrator_controller dic_checker u_dic_checker (.*);
